>>> src/swsr_pkg.sv
// Shared types, constants and helpers for the single-wire sensor receiver.
// No dependencies; used by swsr_engine and single_wire_sensor_receiver_top.
`default_nettype none

package swsr_pkg;

    localparam int DATA_BITS_DEF = 32;
    localparam int CHECK_BITS    = 8;
    localparam int WORD_W        = 32;
    localparam int TICK_W        = 16;
    localparam int TEMP_W        = 9;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ONE_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_LOW     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE       = 2'd2;

    localparam logic [7:0]  ONE_THRESHOLD_RST = 8'd40;
    localparam logic [15:0] START_LOW_RST     = 16'd20000;
    localparam logic [7:0]  RELEASE_RST       = 8'd5;

    typedef enum logic [7:0] {
        PH_IDLE     = 8'b0000_0001,
        PH_LOW      = 8'b0000_0010,
        PH_RELEASE  = 8'b0000_0100,
        PH_ACK_A    = 8'b0000_1000,
        PH_ACK_B    = 8'b0001_0000,
        PH_ACK_C    = 8'b0010_0000,
        PH_BIT_LOW  = 8'b0100_0000,
        PH_BIT_HIGH = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic start_req;
        logic line_level;
    } swsr_in_t;

    typedef struct packed {
        logic              drive_low;
        logic              busy_res;
        logic              reading_done;
        logic              checksum_ok;
        logic [WORD_W-1:0] data_word;
        logic [7:0]        checksum_byte;
        logic [TEMP_W-1:0] temperature;
    } swsr_out_t;

    typedef struct packed {
        logic [7:0]  one_threshold_ticks;
        logic [15:0] start_low_ticks;
        logic [7:0]  release_ticks;
    } swsr_cfg_t;

    // low byte of the four data bytes' sum against the checksum
    function automatic logic sum_ok(input logic [WORD_W-1:0] data, input logic [7:0] chk);
        logic [7:0] s;
        s = data[31:24] + data[23:16] + data[15:8] + data[7:0];
        return s == chk;
    endfunction

    // x / 10 for x < 256 via reciprocal 205 / 2048
    function automatic logic [7:0] div10(input logic [7:0] x);
        logic [15:0] p;
        p = 16'(x) * 16'd205;
        return 8'(p[15:11]);
    endfunction

    function automatic logic [TEMP_W-1:0] temp_of(input logic [WORD_W-1:0] data);
        return {1'b0, data[15:8]} + {1'b0, div10(data[7:0])};
    endfunction

endpackage

`default_nettype wire

>>> src/swsr_engine.sv
// Receive sequencer: start pulse, acknowledge tracking and bit timing, one tick per step.
// Depends on swsr_pkg.
`default_nettype none

module swsr_engine #(
    parameter int DATA_BITS = swsr_pkg::DATA_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                step,
    input  wire swsr_pkg::swsr_in_t  item,
    input  wire swsr_pkg::swsr_cfg_t cfg,
    output swsr_pkg::swsr_out_t      res
);

    localparam int TOTAL_BITS = DATA_BITS + swsr_pkg::CHECK_BITS;
    localparam int BIT_IDX_W  = $clog2(TOTAL_BITS);
    localparam int TW         = swsr_pkg::TICK_W;

    swsr_pkg::phase_t             phase_reg, phase_next, phase_eff;
    logic [TW-1:0]                tick_reg, tick_next, tick_eff, tick_inc;
    logic [BIT_IDX_W-1:0]         bit_idx_reg, bit_idx_next, bit_idx_eff;
    logic [TOTAL_BITS-1:0]        rx_reg, rx_next, rx_eff, rx_shift;
    logic [swsr_pkg::WORD_W-1:0]  last_data_reg, last_data_next;
    logic [7:0]                   last_chk_reg, last_chk_next;
    logic                         start_go, drive, done, bit_val, ok;

    always_comb begin
        start_go    = (phase_reg == swsr_pkg::PH_IDLE) && item.start_req;
        phase_eff   = start_go ? swsr_pkg::PH_LOW : phase_reg;
        tick_eff    = start_go ? '0 : tick_reg;
        bit_idx_eff = start_go ? '0 : bit_idx_reg;
        rx_eff      = start_go ? '0 : rx_reg;
        tick_inc    = (tick_eff == {TW{1'b1}}) ? tick_eff : tick_eff + 1'b1;
        bit_val     = tick_eff > TW'(cfg.one_threshold_ticks);
        rx_shift    = {rx_eff[TOTAL_BITS-2:0], bit_val};

        phase_next     = phase_eff;
        tick_next      = tick_eff;
        bit_idx_next   = bit_idx_eff;
        rx_next        = rx_eff;
        last_data_next = last_data_reg;
        last_chk_next  = last_chk_reg;
        drive          = 1'b0;
        done           = 1'b0;

        case (phase_eff)
            swsr_pkg::PH_IDLE: begin
            end
            swsr_pkg::PH_LOW: begin
                drive     = 1'b1;
                tick_next = tick_inc;
                if (tick_inc >= cfg.start_low_ticks) begin
                    tick_next  = '0;
                    phase_next = (cfg.release_ticks == 8'd0) ? swsr_pkg::PH_ACK_A
                                                             : swsr_pkg::PH_RELEASE;
                end
            end
            swsr_pkg::PH_RELEASE: begin
                tick_next = tick_inc;
                if (tick_inc >= TW'(cfg.release_ticks)) begin
                    tick_next  = '0;
                    phase_next = swsr_pkg::PH_ACK_A;
                end
            end
            swsr_pkg::PH_ACK_A: begin
                if (!item.line_level) phase_next = swsr_pkg::PH_ACK_B;
            end
            swsr_pkg::PH_ACK_B: begin
                if (item.line_level) phase_next = swsr_pkg::PH_ACK_C;
            end
            swsr_pkg::PH_ACK_C: begin
                if (!item.line_level) phase_next = swsr_pkg::PH_BIT_LOW;
            end
            swsr_pkg::PH_BIT_LOW: begin
                if (item.line_level) begin
                    tick_next  = TW'(1);
                    phase_next = swsr_pkg::PH_BIT_HIGH;
                end
            end
            swsr_pkg::PH_BIT_HIGH: begin
                if (item.line_level) begin
                    tick_next = tick_inc;
                end else begin
                    rx_next      = rx_shift;
                    bit_idx_next = bit_idx_eff + 1'b1;
                    tick_next    = '0;
                    if (bit_idx_eff == BIT_IDX_W'(TOTAL_BITS - 1)) begin
                        last_chk_next  = rx_shift[7:0];
                        last_data_next = swsr_pkg::WORD_W'(
                            rx_shift[TOTAL_BITS-1:swsr_pkg::CHECK_BITS]);
                        done       = 1'b1;
                        phase_next = swsr_pkg::PH_IDLE;
                    end else begin
                        phase_next = swsr_pkg::PH_BIT_LOW;
                    end
                end
            end
            default: begin
                phase_next = swsr_pkg::PH_IDLE;
            end
        endcase

        ok                = swsr_pkg::sum_ok(last_data_next, last_chk_next);
        res.drive_low     = drive;
        res.busy_res      = phase_eff != swsr_pkg::PH_IDLE;
        res.reading_done  = done;
        res.checksum_ok   = ok;
        res.data_word     = last_data_next;
        res.checksum_byte = last_chk_next;
        res.temperature   = ok ? swsr_pkg::temp_of(last_data_next) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= swsr_pkg::PH_IDLE;
            tick_reg      <= '0;
            bit_idx_reg   <= '0;
            rx_reg        <= '0;
            last_data_reg <= '0;
            last_chk_reg  <= '0;
        end else if (step) begin
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            bit_idx_reg   <= bit_idx_next;
            rx_reg        <= rx_next;
            last_data_reg <= last_data_next;
            last_chk_reg  <= last_chk_next;
        end
    end

endmodule

`default_nettype wire

>>> src/single_wire_sensor_receiver_top.sv
// Single-wire pulse-width sensor receiver: top level with config registers and result register.
// Depends on swsr_pkg and swsr_engine.
//
// Usage:
//   s_valid/s_ready/s_item carry one request per microsecond tick (start_req, line_level).
//   m_valid/m_ready/m_item return exactly one result per request, in order.
//   cfg_wr_en/cfg_index/cfg_wdata write the threshold, start-low and release times;
//   write only while idle. Unknown indexes are ignored.
//   Latency: a result is valid the cycle after its request is taken.
//   Throughput: one request per cycle while m_ready does not hold back a pending result; all tick
//   processing is one pass of logic between the sequencer state and the result register.
//   s_ready is high whenever the result register is empty or being read, so a
//   stalled receiver holds the pending result and stops intake after one request.
//   Reset: sequencer idle, stored reading zero (checksum_ok 1, temperature 0),
//   registers to 40 / 20000 / 5, no result pending.
//   No timeout: a silent line keeps the sequencer waiting until reset.
`default_nettype none

module single_wire_sensor_receiver_top #(
    parameter int DATA_BITS = swsr_pkg::DATA_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire swsr_pkg::swsr_in_t                 s_item,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output swsr_pkg::swsr_out_t                     m_item,
    input  wire logic                               cfg_wr_en,
    input  wire logic [swsr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [swsr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    swsr_pkg::swsr_cfg_t cfg_reg;
    swsr_pkg::swsr_out_t res, m_item_reg;
    logic                m_valid_reg;
    logic                take;

    assign s_ready = !m_valid_reg || m_ready;
    assign take    = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.one_threshold_ticks <= swsr_pkg::ONE_THRESHOLD_RST;
            cfg_reg.start_low_ticks     <= swsr_pkg::START_LOW_RST;
            cfg_reg.release_ticks       <= swsr_pkg::RELEASE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                swsr_pkg::REG_ONE_THRESHOLD: cfg_reg.one_threshold_ticks <= cfg_wdata[7:0];
                swsr_pkg::REG_START_LOW:     cfg_reg.start_low_ticks     <= cfg_wdata;
                swsr_pkg::REG_RELEASE:       cfg_reg.release_ticks       <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    swsr_engine #(
        .DATA_BITS(DATA_BITS)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (take),
        .item    (s_item),
        .cfg     (cfg_reg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            m_item_reg <= res;
        end
    end

    a_take_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted request produced no result");

    a_done_is_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.reading_done |-> m_item.busy_res && !m_item.drive_low)
        else $error("reading_done outside a busy tick");

    a_drive_is_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.drive_low |-> m_item.busy_res)
        else $error("line driven while idle");

    a_thr_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en && cfg_index == swsr_pkg::REG_ONE_THRESHOLD
        |=> cfg_reg.one_threshold_ticks == $past(cfg_wdata[7:0]))
        else $error("threshold register write lost");

endmodule

`default_nettype wire

>>> sim/swsr_reading_checker.sv
`timescale 1ns / 1ps
// Result checker for single_wire_sensor_receiver_top: mirrors the sequencer tick by tick,
// queues one predicted result per accepted request and compares the result channel.
// Depends on swsr_pkg.

module swsr_reading_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  swsr_pkg::swsr_in_t                s_item,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  swsr_pkg::swsr_out_t               m_item,
    input  logic                              cfg_wr_en,
    input  logic [swsr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [swsr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output int                                errors,
    output int                                pending
);

    localparam int FRAME_BITS = swsr_pkg::DATA_BITS_DEF + swsr_pkg::CHECK_BITS;

    logic [7:0]                    thr_ticks;
    logic [15:0]                   low_ticks;
    logic [7:0]                    rel_ticks;

    swsr_pkg::phase_t              seq_phase;
    logic [15:0]                   pulse_ticks;
    logic [5:0]                    bits_seen;
    logic [FRAME_BITS-1:0]         frame_bits;
    logic [swsr_pkg::WORD_W-1:0]   held_word;
    logic [7:0]                    held_chk;

    swsr_pkg::swsr_out_t           due_results[$];

    function automatic logic [15:0] bump(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic swsr_pkg::swsr_out_t advance_tick(input swsr_pkg::swsr_in_t req);
        swsr_pkg::swsr_out_t r;
        logic [7:0]          bsum;
        r = '0;
        if (seq_phase == swsr_pkg::PH_IDLE && req.start_req) begin
            seq_phase   = swsr_pkg::PH_LOW;
            pulse_ticks = '0;
            bits_seen   = '0;
            frame_bits  = '0;
        end
        r.busy_res = (seq_phase != swsr_pkg::PH_IDLE);
        case (seq_phase)
            swsr_pkg::PH_IDLE: ;
            swsr_pkg::PH_LOW: begin
                r.drive_low = 1'b1;
                pulse_ticks = bump(pulse_ticks);
                if (pulse_ticks >= low_ticks) begin
                    pulse_ticks = '0;
                    seq_phase   = (rel_ticks == 8'd0) ? swsr_pkg::PH_ACK_A
                                                      : swsr_pkg::PH_RELEASE;
                end
            end
            swsr_pkg::PH_RELEASE: begin
                pulse_ticks = bump(pulse_ticks);
                if (pulse_ticks >= {8'd0, rel_ticks}) begin
                    pulse_ticks = '0;
                    seq_phase   = swsr_pkg::PH_ACK_A;
                end
            end
            swsr_pkg::PH_ACK_A: if (!req.line_level) seq_phase = swsr_pkg::PH_ACK_B;
            swsr_pkg::PH_ACK_B: if (req.line_level) seq_phase = swsr_pkg::PH_ACK_C;
            swsr_pkg::PH_ACK_C: if (!req.line_level) seq_phase = swsr_pkg::PH_BIT_LOW;
            swsr_pkg::PH_BIT_LOW: begin
                if (req.line_level) begin
                    pulse_ticks = 16'd1;
                    seq_phase   = swsr_pkg::PH_BIT_HIGH;
                end
            end
            swsr_pkg::PH_BIT_HIGH: begin
                if (req.line_level) begin
                    pulse_ticks = bump(pulse_ticks);
                end else begin
                    frame_bits  = {frame_bits[FRAME_BITS-2:0], pulse_ticks > {8'd0, thr_ticks}};
                    bits_seen   = bits_seen + 6'd1;
                    pulse_ticks = '0;
                    if (bits_seen >= FRAME_BITS) begin
                        held_chk       = frame_bits[7:0];
                        held_word      = frame_bits[FRAME_BITS-1:swsr_pkg::CHECK_BITS];
                        r.reading_done = 1'b1;
                        seq_phase      = swsr_pkg::PH_IDLE;
                    end else begin
                        seq_phase = swsr_pkg::PH_BIT_LOW;
                    end
                end
            end
            default: seq_phase = swsr_pkg::PH_IDLE;
        endcase
        bsum = held_word[31:24] + held_word[23:16] + held_word[15:8] + held_word[7:0];
        r.checksum_ok   = (bsum == held_chk);
        r.data_word     = held_word;
        r.checksum_byte = held_chk;
        r.temperature   = r.checksum_ok ?
                          swsr_pkg::TEMP_W'(held_word[15:8])
                          + swsr_pkg::TEMP_W'(held_word[7:0] / 8'd10) : '0;
        return r;
    endfunction

    task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
        errors++;
        $display("%0t %s mismatch: expected %0h, got %0h", $time, what, want, got);
    endtask

    task automatic check_result(input swsr_pkg::swsr_out_t want,
                                input swsr_pkg::swsr_out_t got);
        if (got.drive_low !== want.drive_low)
            flag("drive_low", want.drive_low, got.drive_low);
        if (got.busy_res !== want.busy_res)
            flag("busy_res", want.busy_res, got.busy_res);
        if (got.reading_done !== want.reading_done)
            flag("reading_done", want.reading_done, got.reading_done);
        if (got.checksum_ok !== want.checksum_ok)
            flag("checksum_ok", want.checksum_ok, got.checksum_ok);
        if (got.data_word !== want.data_word)
            flag("data_word", want.data_word, got.data_word);
        if (got.checksum_byte !== want.checksum_byte)
            flag("checksum_byte", want.checksum_byte, got.checksum_byte);
        if (got.temperature !== want.temperature)
            flag("temperature", want.temperature, got.temperature);
    endtask

    initial begin
        errors  = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            thr_ticks   = swsr_pkg::ONE_THRESHOLD_RST;
            low_ticks   = swsr_pkg::START_LOW_RST;
            rel_ticks   = swsr_pkg::RELEASE_RST;
            seq_phase   = swsr_pkg::PH_IDLE;
            pulse_ticks = '0;
            bits_seen   = '0;
            frame_bits  = '0;
            held_word   = '0;
            held_chk    = '0;
            due_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    errors++;
                    $display("%0t unexpected result: expected none, got %0h", $time, m_item);
                end else begin
                    check_result(due_results.pop_front(), m_item);
                end
            end
            if (s_valid && s_ready)
                due_results.push_back(advance_tick(s_item));
            if (cfg_wr_en) begin
                case (cfg_index)
                    swsr_pkg::REG_ONE_THRESHOLD: thr_ticks = cfg_wdata[7:0];
                    swsr_pkg::REG_START_LOW:     low_ticks = cfg_wdata;
                    swsr_pkg::REG_RELEASE:       rel_ticks = cfg_wdata[7:0];
                    default: ;
                endcase
            end
        end
        pending = due_results.size();
    end

endmodule

>>> sim/single_wire_sensor_receiver_top_tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for single_wire_sensor_receiver_top: plays a sensor on the line,
// one request per tick, across several register settings. Depends on swsr_pkg and
// swsr_reading_checker.

module single_wire_sensor_receiver_top_tb;

    localparam logic [swsr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int FRAME_BITS = swsr_pkg::DATA_BITS_DEF + swsr_pkg::CHECK_BITS;

    logic                                aclk      = 1'b0;
    logic                                aresetn   = 1'b0;
    logic                                s_valid   = 1'b0;
    logic                                s_ready;
    swsr_pkg::swsr_in_t                  s_item    = '0;
    logic                                m_valid;
    logic                                m_ready   = 1'b0;
    swsr_pkg::swsr_out_t                 m_item;
    logic                                cfg_wr_en = 1'b0;
    logic [swsr_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [swsr_pkg::CFG_DATA_W-1:0]     cfg_wdata = '0;

    int                                  errors;
    int                                  pending;

    int                                  send_idle_pct = 34;
    int                                  recv_idle_pct = 46;
    logic                                in_reading    = 1'b0;
    int                                  reading_items = 0;
    logic [7:0]                          cfg_thr       = swsr_pkg::ONE_THRESHOLD_RST;
    logic [15:0]                         cfg_low       = swsr_pkg::START_LOW_RST;
    logic [7:0]                          cfg_rel       = swsr_pkg::RELEASE_RST;

    single_wire_sensor_receiver_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    swsr_reading_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        #1_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_tick(input logic st, input logic ln);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= '{start_req: st, line_level: ln};
        if (in_reading) reading_items++;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic busy_start();
        return $urandom_range(7) == 0;
    endfunction

    task automatic send_level(input logic lvl, input int n, input logic may_start);
        repeat (n) send_tick(may_start ? busy_start() : 1'b0, lvl);
    endtask

    function automatic int high_ticks(input logic one);
        return one ? $urandom_range(int'(cfg_thr) + 3, int'(cfg_thr) + 1)
                   : $urandom_range(int'(cfg_thr), 1);
    endfunction

    function automatic logic [7:0] byte_sum(input logic [31:0] w);
        return w[31:24] + w[23:16] + w[15:8] + w[7:0];
    endfunction

    // first_high > 0 overrides the high time of the first bit; cut < 40 breaks the frame
    task automatic do_reading(input logic [31:0] word, input logic [7:0] chk,
                              input int first_high, input int cut);
        logic [FRAME_BITS-1:0] frame;
        int                    hi;
        frame      = {word, chk};
        in_reading = 1'b1;
        send_tick(1'b1, 1'($urandom));
        repeat (int'(cfg_low) + int'(cfg_rel) - 1) send_tick(busy_start(), 1'($urandom));
        send_level(1'b1, $urandom_range(2), 1'b1);
        send_level(1'b0, $urandom_range(3, 1), 1'b1);
        send_level(1'b1, $urandom_range(3, 1), 1'b1);
        send_level(1'b0, $urandom_range(3, 1), 1'b1);
        for (int i = FRAME_BITS - 1; i >= FRAME_BITS - cut; i--) begin
            hi = (i == FRAME_BITS - 1 && first_high > 0) ? first_high : high_ticks(frame[i]);
            send_level(1'b1, hi, 1'b1);
            send_level(1'b0, $urandom_range(3, 1), i != 0);
        end
        if (cut < FRAME_BITS) begin
            repeat ($urandom_range(20)) send_tick(1'b0, 1'($urandom));
            // toggling long enough to finish any partial frame
            repeat (FRAME_BITS + 4) begin
                send_tick(1'b0, 1'b0);
                send_tick(1'b0, 1'b1);
            end
            send_tick(1'b0, 1'b0);
        end
        in_reading = 1'b0;
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [swsr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [swsr_pkg::CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic program_cfg(input logic [7:0] thr, input logic [15:0] low,
                               input logic [7:0] rel);
        write_reg(swsr_pkg::REG_ONE_THRESHOLD, {8'($urandom), thr});
        write_reg(swsr_pkg::REG_START_LOW, low);
        write_reg(swsr_pkg::REG_RELEASE, {8'($urandom), rel});
        cfg_thr = thr;
        cfg_low = low;
        cfg_rel = rel;
    endtask

    task automatic random_episode();
        logic [31:0] w;
        int          pick;
        w    = $urandom;
        pick = $urandom_range(99);
        if (pick < 70)
            do_reading(w, ($urandom_range(3) == 0) ? 8'($urandom) : byte_sum(w), 0, FRAME_BITS);
        else if (pick < 85)
            do_reading(w, 8'($urandom), 0, $urandom_range(FRAME_BITS - 1));
        else
            repeat ($urandom_range(12, 1)) send_tick(1'b0, 1'($urandom));
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // idle line before any reading
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);

        // short start pulse, reset threshold and release; first bit just above threshold
        settle();
        write_reg(swsr_pkg::REG_START_LOW, 16'd2);
        cfg_low = 16'd2;
        do_reading(32'h0000_FFFF, 8'hFE, int'(cfg_thr) + 1, 1);

        settle();
        write_reg(REG_UNUSED, 16'hFFFF);
        program_cfg(8'd1, 16'd1, 8'd0);
        do_reading(32'hFFFF_FFFF, 8'hFC, 0, FRAME_BITS);
        send_tick(1'b0, 1'b1);

        for (int p = 0; p < 3; p++) begin
            settle();
            send_idle_pct = (p == 0) ? 34 : (p == 1) ? 46 : 0;
            recv_idle_pct = (p == 0) ? 46 : (p == 1) ? 34 : 0;
            program_cfg(8'($urandom_range(3, 1)), 16'($urandom_range(4, 1)),
                        8'($urandom_range(3)));
            reading_items = 0;
            while (reading_items < 100) random_episode();
        end

        settle();
        repeat (4) @(negedge aclk);
        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
